// ===== sv/u64dd_pkg.sv =====
// Shared constants and types for the 64-bit to decimal digit converter.
// No dependencies; imported by every module of the block.
package u64dd_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int MAX_DIGITS  = 20;
	localparam int IN_W        = 64;
	localparam int CHAR_W      = 6;
	localparam int COUNT_W     = 5;
	localparam int BCD_W       = 4 * MAX_DIGITS;
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
	localparam int POS_W       = $clog2(MAX_DIGITS);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
	localparam logic [3:0]        RADIX      = 4'd10;

	typedef struct packed {
		logic [BCD_W-1:0]   bcd;
		logic [COUNT_W-1:0] count;
	} conv_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== sv/u64_to_decimal_digits_core.sv =====
// Unsigned 64-bit to decimal ASCII converter, top level.
// Instantiates u64dd_front, u64dd_queue and u64dd_back; uses u64dd_pkg.
//
// A request is taken when start is high and busy is low. The front runs
// shift-add-3 one input bit per clock, so busy stays high through the shift
// of every input bit and the hand-over to the queue, longer only while the
// two-entry queue is full. The back loads a queued value and then
// presents one digit per cycle, most significant first, each for one cycle
// with strobe high; last marks the final digit. The receiver cannot stall:
// digits must be taken as they appear. Front and back overlap, so the
// front can take a new request while the back still emits the digits of
// an earlier value.
module u64_to_decimal_digits_core import u64dd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [IN_W-1:0]    value,
	output logic               strobe,
	output logic [CHAR_W-1:0]  digit_char,
	output logic [COUNT_W-1:0] digit_count,
	output logic               last
);

	q_stat_t qstat;
	logic    push;
	logic    pop;
	conv_t   push_data;
	conv_t   pop_data;

	u64dd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	u64dd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	u64dd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.pop_data    (pop_data),
		.pop         (pop),
		.strobe      (strobe),
		.digit_char  (digit_char),
		.digit_count (digit_count),
		.last        (last)
	);

endmodule

// ===== sv/u64dd_front.sv =====
// Front end: accepts a request and runs shift-add-3 one bit per clock.
// Hands BCD digits and digit count to the queue. Depends on u64dd_pkg.
module u64dd_front import u64dd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IN_W-1:0]  value,
	output logic             busy,
	input  q_stat_t          qstat,
	output logic             push,
	output conv_t            push_data
);

	typedef enum logic [1:0] {F_IDLE, F_SHIFT, F_PUSH} fstate_t;

	fstate_t                state_q;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BIT_CNT_W-1:0]   bit_q;
	logic [BCD_W-1:0]       adj;
	logic [COUNT_W-1:0]     cnt;

	always_comb begin
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] >= 4'd5) begin
				adj[d*4 +: 4] = bcd_q[d*4 +: 4] + 4'd3;
			end else begin
				adj[d*4 +: 4] = bcd_q[d*4 +: 4];
			end
		end
	end

	always_comb begin
		cnt = COUNT_W'(1);
		for (int d = 1; d < MAX_DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				cnt = COUNT_W'(d + 1);
			end
		end
	end

	assign busy            = (state_q != F_IDLE);
	assign push            = (state_q == F_PUSH) && !qstat.full;
	assign push_data.bcd   = bcd_q;
	assign push_data.count = cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			bit_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_SHIFT;
						bit_q   <= '0;
					end
				end
				F_SHIFT: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!qstat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			bin_q <= value[VALUE_WIDTH-1:0];
			bcd_q <= '0;
		end else if (state_q == F_SHIFT) begin
			bin_q <= bin_q << 1;
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
		end
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("front not busy after accepting a request");
	a_shift_to_push: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_SHIFT && bit_q == BIT_CNT_W'(VALUE_WIDTH - 1) |=> state_q == F_PUSH)
		else $error("front missed hand-over after last bit");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> cnt >= COUNT_W'(1) && cnt <= COUNT_W'(MAX_DIGITS))
		else $error("digit count out of range");
`endif

endmodule

// ===== sv/u64dd_queue.sv =====
// Short queue of converted values between front and back.
// Depends on u64dd_pkg for the entry and status types.
module u64dd_queue import u64dd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  conv_t   push_data,
	input  logic    pop,
	output conv_t   pop_data,
	output q_stat_t qstat
);

	conv_t             mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign qstat.full  = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_data    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("pop from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W + 1)'(QDEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// ===== sv/u64dd_back.sv =====
// Back end: takes one converted value from the queue and emits its digits,
// most significant first, one per clock. Depends on u64dd_pkg.
module u64dd_back import u64dd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  q_stat_t            qstat,
	input  conv_t              pop_data,
	output logic               pop,
	output logic               strobe,
	output logic [CHAR_W-1:0]  digit_char,
	output logic [COUNT_W-1:0] digit_count,
	output logic               last
);

	typedef enum logic {B_IDLE, B_EMIT} bstate_t;

	bstate_t            state_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [COUNT_W-1:0] count_q;
	logic [POS_W-1:0]   pos_q;
	logic [3:0]         dig;
	logic [3:0]         dig_c;

	assign pop   = (state_q == B_IDLE) && !qstat.empty;
	assign dig   = bcd_q[pos_q*4 +: 4];
	assign dig_c = (dig >= RADIX) ? RADIX - 4'd1 : dig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			strobe  <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					strobe <= 1'b0;
					if (!qstat.empty) begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					strobe <= 1'b1;
					if (pos_q == '0) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bcd_q   <= pop_data.bcd;
			count_q <= pop_data.count;
			pos_q   <= POS_W'(pop_data.count - COUNT_W'(1));
		end else if (state_q == B_EMIT) begin
			pos_q       <= pos_q - 1'b1;
			digit_char  <= ASCII_ZERO + CHAR_W'(dig_c);
			digit_count <= count_q;
			last        <= (pos_q == '0);
		end
	end

`ifndef SYNTHESIS
	a_digits_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside a digit run");
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("digit run did not close after last");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == B_EMIT)
		else $error("pop without entering emit");
`endif

endmodule
